// ===== hdl/bpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsd_pkg
// types and constants shared by the bmp pixel stream decoder
// ----------------------------------------------------------------------------
package bpsd_pkg;

   localparam int MAX_DIMENSION   = 4096;
   localparam int PALETTE_ENTRIES = 256;

   localparam logic [1:0] OP_PIXEL   = 2'd0;
   localparam logic [1:0] OP_PALETTE = 2'd1;
   localparam logic [1:0] OP_START   = 2'd2;

   localparam logic [1:0] DEPTH_4BIT  = 2'd0;
   localparam logic [1:0] DEPTH_8BIT  = 2'd1;
   localparam logic [1:0] DEPTH_24BIT = 2'd2;

   localparam logic [1:0] REG_DEPTH  = 2'd0;
   localparam logic [1:0] REG_RLE    = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;

   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   // parser phase; for 24-bit data the first three double as the byte counter
   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_RUN  = 6'b000010,
      PH_ESC  = 6'b000100,
      PH_DX   = 6'b001000,
      PH_DY   = 6'b010000,
      PH_ABS  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [1:0]  depth;
      logic        rle;
      logic [12:0] width;
      logic [12:0] height;
   } cfg_type;

   typedef struct packed {
      logic        emit;
      logic [11:0] row;
      logic [11:0] col;
      logic [7:0]  len;
      logic        done;
      logic        direct;
      logic [23:0] color;
      logic [7:0]  even_idx;
      logic [7:0]  odd_idx;
   } span_type;

endpackage

// ===== hdl/bpsd_palette.sv =====
// ----------------------------------------------------------------------------
// bpsd_palette
// colour table ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module bpsd_palette #(
   parameter int PALETTE_ENTRIES = bpsd_pkg::PALETTE_ENTRIES
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_idx,
   input  logic [23:0] wr_data,
   input  logic        rd_en,
   input  logic [7:0]  rd_idx_a,
   input  logic [7:0]  rd_idx_b,
   output logic [23:0] rd_data_a,
   output logic [23:0] rd_data_b
);
   localparam int AW = $clog2(PALETTE_ENTRIES);

   logic [23:0]   mem [PALETTE_ENTRIES];
   logic [23:0]   data_a_ff, data_b_ff;
   logic          ok_a_ff, ok_b_ff;
   logic          ok_a_in, ok_b_in, ok_w;
   logic [AW-1:0] addr_a, addr_b, addr_w;

   assign ok_a_in = {1'b0, rd_idx_a} < 9'(PALETTE_ENTRIES);
   assign ok_b_in = {1'b0, rd_idx_b} < 9'(PALETTE_ENTRIES);
   assign ok_w    = {1'b0, wr_idx}   < 9'(PALETTE_ENTRIES);
   assign addr_a  = ok_a_in ? rd_idx_a[AW-1:0] : '0;
   assign addr_b  = ok_b_in ? rd_idx_b[AW-1:0] : '0;
   assign addr_w  = wr_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en && ok_w) begin
         mem[addr_w] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[addr_a];
         data_b_ff <= mem[addr_b];
         ok_a_ff   <= ok_a_in;
         ok_b_ff   <= ok_b_in;
      end
   end

   assign rd_data_a = ok_a_ff ? data_a_ff : 24'd0;
   assign rd_data_b = ok_b_ff ? data_b_ff : 24'd0;

endmodule

// ===== hdl/bpsd_parser.sv =====
// ----------------------------------------------------------------------------
// bpsd_parser
// byte parser for raw and rle rows, tracks position and builds spans
// ----------------------------------------------------------------------------
module bpsd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [1:0]         op,
   input  logic [7:0]         data_byte,
   input  bpsd_pkg::cfg_type  cfg,
   output bpsd_pkg::span_type span
);
   bpsd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] col_ff, col_in, line_ff, line_in;
   logic [8:0]  left_ff, left_in;
   logic [7:0]  abs_ff, abs_in;
   logic [15:0] rbc_ff, rbc_in;
   logic [7:0]  blue_ff, blue_in, green_ff, green_in;
   logic        fin_ff, fin_in;

   logic [15:0] w, h, dbytes, rbytes, span_col;
   logic [16:0] rbc_next, sum;
   logic [1:0]  depth;
   logic        four, do_span, raw, eob, direct, row_end, span_ok, done;
   logic [8:0]  cnt, data, tot, idx;
   logic [9:0]  n;
   logic [15:0] room, len16;
   logic [23:0] color;
   logic [7:0]  ei, oi;

   always_comb begin
      w = (cfg.width == 13'd0) ? 16'd1 :
          ({3'd0, cfg.width} > 16'(bpsd_pkg::MAX_DIMENSION)) ?
          16'(bpsd_pkg::MAX_DIMENSION) : {3'd0, cfg.width};
      h = (cfg.height == 13'd0) ? 16'd1 :
          ({3'd0, cfg.height} > 16'(bpsd_pkg::MAX_DIMENSION)) ?
          16'(bpsd_pkg::MAX_DIMENSION) : {3'd0, cfg.height};
      depth = (cfg.depth == 2'd3) ? bpsd_pkg::DEPTH_24BIT : cfg.depth;
      four  = depth == bpsd_pkg::DEPTH_4BIT;
      unique case (depth)
         bpsd_pkg::DEPTH_4BIT: dbytes = 16'((17'(w) + 17'd1) >> 1);
         bpsd_pkg::DEPTH_8BIT: dbytes = w;
         default:              dbytes = w + {w[14:0], 1'b0};
      endcase
      rbytes   = (dbytes + 16'd3) & ~16'd3;
      rbc_next = 17'(rbc_ff) + 17'd1;
      data     = four ? 9'((10'(abs_ff) + 10'd1) >> 1) : {1'b0, abs_ff};
      tot      = data + {8'd0, data[0]};
      idx      = (left_ff <= tot) ? tot - left_ff : tot;
      n        = {2'd0, abs_ff} - {idx, 1'b0};

      phase_in = phase_ff;
      col_in   = col_ff;
      line_in  = line_ff;
      left_in  = left_ff;
      abs_in   = abs_ff;
      rbc_in   = rbc_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      fin_in   = fin_ff;
      cnt      = 9'd0;
      do_span  = 1'b0;
      raw      = 1'b0;
      eob      = 1'b0;
      direct   = 1'b0;
      row_end  = 1'b0;
      color    = 24'd0;
      ei       = data_byte;
      oi       = data_byte;
      sum      = 17'd0;

      if (four) begin
         ei = {4'd0, data_byte[7:4]};
         oi = {4'd0, data_byte[3:0]};
      end

      if (op == bpsd_pkg::OP_START) begin
         phase_in = bpsd_pkg::PH_IDLE;
         col_in   = '0;
         line_in  = '0;
         left_in  = '0;
         abs_in   = '0;
         rbc_in   = '0;
         blue_in  = '0;
         green_in = '0;
         fin_in   = 1'b0;
      end else if (op == bpsd_pkg::OP_PIXEL && !fin_ff) begin
         if (cfg.rle && depth != bpsd_pkg::DEPTH_24BIT) begin
            unique case (phase_ff)
               bpsd_pkg::PH_RUN: begin
                  cnt      = left_ff;
                  do_span  = 1'b1;
                  left_in  = '0;
                  phase_in = bpsd_pkg::PH_IDLE;
               end
               bpsd_pkg::PH_ESC: begin
                  phase_in = bpsd_pkg::PH_IDLE;
                  if (data_byte == bpsd_pkg::ESC_EOL) begin
                     col_in  = '0;
                     line_in = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
                  end else if (data_byte == bpsd_pkg::ESC_EOB) begin
                     fin_in = 1'b1;
                     eob    = 1'b1;
                     direct = 1'b1;
                  end else if (data_byte == bpsd_pkg::ESC_DELTA) begin
                     phase_in = bpsd_pkg::PH_DX;
                  end else begin
                     abs_in   = data_byte;
                     left_in  = (four ? 9'((10'(data_byte) + 10'd1) >> 1)
                                      : {1'b0, data_byte});
                     left_in  = left_in + {8'd0, left_in[0]};
                     phase_in = bpsd_pkg::PH_ABS;
                  end
               end
               bpsd_pkg::PH_DX: begin
                  sum      = 17'(col_ff) + 17'(data_byte);
                  col_in   = sum[16] ? 16'hFFFF : sum[15:0];
                  phase_in = bpsd_pkg::PH_DY;
               end
               bpsd_pkg::PH_DY: begin
                  sum      = 17'(line_ff) + 17'(data_byte);
                  line_in  = sum[16] ? 16'hFFFF : sum[15:0];
                  phase_in = bpsd_pkg::PH_IDLE;
               end
               bpsd_pkg::PH_ABS: begin
                  left_in = (left_ff != 9'd0) ? left_ff - 9'd1 : left_ff;
                  if (left_in == 9'd0) begin
                     phase_in = bpsd_pkg::PH_IDLE;
                  end
                  if (idx < data) begin
                     do_span = 1'b1;
                     cnt     = four ? ((n > 10'd2) ? 9'd2 : n[8:0]) : 9'd1;
                  end
               end
               default: begin
                  if (data_byte != 8'd0) begin
                     left_in  = {1'b0, data_byte};
                     phase_in = bpsd_pkg::PH_RUN;
                  end else begin
                     phase_in = bpsd_pkg::PH_ESC;
                  end
               end
            endcase
         end else begin
            raw = 1'b1;
            if (rbc_ff < dbytes) begin
               if (depth == bpsd_pkg::DEPTH_4BIT) begin
                  cnt     = 9'd2;
                  do_span = 1'b1;
               end else if (depth == bpsd_pkg::DEPTH_8BIT) begin
                  cnt     = 9'd1;
                  do_span = 1'b1;
               end else if (phase_ff == bpsd_pkg::PH_IDLE) begin
                  blue_in  = data_byte;
                  phase_in = bpsd_pkg::PH_RUN;
               end else if (phase_ff == bpsd_pkg::PH_RUN) begin
                  green_in = data_byte;
                  phase_in = bpsd_pkg::PH_ESC;
               end else begin
                  color    = {data_byte, green_ff, blue_ff};
                  direct   = 1'b1;
                  phase_in = bpsd_pkg::PH_IDLE;
                  cnt      = 9'd1;
                  do_span  = 1'b1;
               end
            end
            rbc_in = rbc_next[15:0];
            if (rbc_next >= 17'(rbytes)) begin
               row_end = 1'b1;
            end
         end
      end

      // clip to the image width
      room     = w - col_ff;
      len16    = (col_ff < w) ? ((16'(cnt) < room) ? 16'(cnt) : room) : 16'd0;
      span_col = col_ff + len16;
      span_ok  = do_span && len16 != 16'd0 && line_ff < h;
      done     = raw && line_ff == h - 16'd1 && span_col >= w;
      if (do_span) begin
         col_in = span_col;
      end
      if (span_ok && done) begin
         fin_in = 1'b1;
      end
      if (row_end) begin
         rbc_in   = '0;
         col_in   = '0;
         line_in  = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
         phase_in = bpsd_pkg::PH_IDLE;
      end

      span.emit     = span_ok || eob;
      span.row      = eob ? 12'd0 : 12'(h - 16'd1 - line_ff);
      span.col      = eob ? 12'd0 : col_ff[11:0];
      span.len      = eob ? 8'd0 : len16[7:0];
      span.done     = eob || done;
      span.direct   = direct;
      span.color    = color;
      span.even_idx = ei;
      span.odd_idx  = oi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bpsd_pkg::PH_IDLE;
         col_ff   <= '0;
         line_ff  <= '0;
         left_ff  <= '0;
         abs_ff   <= '0;
         rbc_ff   <= '0;
         blue_ff  <= '0;
         green_ff <= '0;
         fin_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         left_ff  <= left_in;
         abs_ff   <= abs_in;
         rbc_ff   <= rbc_in;
         blue_ff  <= blue_in;
         green_ff <= green_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// ===== hdl/bmp_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// decodes bmp pixel-array bytes (raw, rle4, rle8, 24-bit) into colour spans
// ----------------------------------------------------------------------------
//  channel | direction | transfer      | payload
//  req_    | in        | tvalid/tready | tuser operation, tdata byte and palette
//  rsp_    | out       | tvalid/tready | tdata span, tlast image_done
//  csr_    | in        | valid/ready   | index, data
//
// one byte per cycle unless input stalls; each span is registered in the palette
// ram read stage and then in the output register. the palette ram and the
// output register give two result slots, so input stalls only when both are
// full and rsp_tready is low. reset clears parse state and registers; the
// palette is undefined until written. csr_ready is always high.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder #(
   parameter int PALETTE_ENTRIES = bpsd_pkg::PALETTE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // operation
   // data_byte, palette_index, palette_red, palette_green, palette_blue
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // display_row, start_column, span_length, even_red, even_green,
   // even_blue, odd_red, odd_green, odd_blue
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast,   // image_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   bpsd_pkg::cfg_type  cfg_ff;
   bpsd_pkg::span_type span, s2_ff;
   logic        s2_valid_ff, rsp_valid_ff, rsp_last_ff;
   logic [79:0] rsp_data_ff;
   logic        fire, s2_move;
   logic [23:0] pal_a, pal_b, even_c, odd_c;

   assign csr_ready  = 1'b1;
   assign s2_move    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s2_valid_ff || s2_move;
   assign fire       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth  <= bpsd_pkg::DEPTH_8BIT;
         cfg_ff.rle    <= 1'b0;
         cfg_ff.width  <= 13'd1;
         cfg_ff.height <= 13'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            bpsd_pkg::REG_DEPTH:  cfg_ff.depth  <= csr_data[1:0];
            bpsd_pkg::REG_RLE:    cfg_ff.rle    <= csr_data[0];
            bpsd_pkg::REG_WIDTH:  cfg_ff.width  <= csr_data;
            bpsd_pkg::REG_HEIGHT: cfg_ff.height <= csr_data;
         endcase
      end
   end

   bpsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .op        (req_tuser),
      .data_byte (req_tdata[7:0]),
      .cfg       (cfg_ff),
      .span      (span)
   );

   bpsd_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock     (clock),
      .wr_en     (fire && req_tuser == bpsd_pkg::OP_PALETTE),
      .wr_idx    (req_tdata[15:8]),
      .wr_data   ({req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]}),
      .rd_en     (fire),
      .rd_idx_a  (span.even_idx),
      .rd_idx_b  (span.odd_idx),
      .rd_data_a (pal_a),
      .rd_data_b (pal_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            s2_valid_ff <= span.emit;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_move) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s2_ff <= span;
      end
      if (s2_move && s2_valid_ff) begin
         rsp_data_ff <= {odd_c[7:0], odd_c[15:8], odd_c[23:16],
                         even_c[7:0], even_c[15:8], even_c[23:16],
                         s2_ff.len, s2_ff.col, s2_ff.row};
         rsp_last_ff <= s2_ff.done;
      end
   end

   assign even_c = s2_ff.direct ? s2_ff.color : pal_a;
   assign odd_c  = s2_ff.direct ? s2_ff.color : pal_b;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== tb/bmp_pixel_stream_decoder_test.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_test
// self-checking test of the bmp pixel stream decoder: a palette load, directed
// rle4/rle8 escapes, then random rle sequences and raw rows under
// several register settings. every accepted byte is run through a span
// predictor, and each span on the response channel is compared field by field
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_test;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 600000;

   typedef enum int {RLE_IDLE, RLE_RUN, RLE_ESC, RLE_DX, RLE_DY, RLE_ABS} rle_state_type;

   class span_scoreboard;
      int unsigned depth, rle, width, height, w, h;
      logic [23:0] colors [256];
      rle_state_type state;
      int unsigned col, line, run_left, abs_total, row_bytes, bgr_step;
      logic [23:0] bgr;
      bit          finished;
      logic [80:0] spans [$];
      int          errors;

      function void restart();
         state = RLE_IDLE; col = 0; line = 0; run_left = 0; abs_total = 0;
         row_bytes = 0; bgr_step = 0; bgr = 0; finished = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [12:0] v);
         case (idx)
            bpsd_pkg::REG_DEPTH:  depth = v[1:0];
            bpsd_pkg::REG_RLE:    rle = v[0];
            bpsd_pkg::REG_WIDTH:  width = v;
            bpsd_pkg::REG_HEIGHT: height = v;
         endcase
      endfunction

      function int unsigned clamp_dim(int unsigned v);
         if (v == 0) return 1;
         return v > bpsd_pkg::MAX_DIMENSION ? bpsd_pkg::MAX_DIMENSION : v;
      endfunction

      function int unsigned sat16(int unsigned v);
         return v > 65535 ? 65535 : v;
      endfunction

      function void place(int unsigned n, logic [23:0] ce, logic [23:0] co, bit raw);
         int unsigned c, len;
         bit done;
         c = col;
         len = 0;
         if (c < w) len = n < w - c ? n : w - c;
         col = sat16(c + len);
         if (len == 0 || line >= h) return;
         done = raw && line == h - 1 && col >= w;
         if (done) finished = 1;
         spans.push_back({done, co[7:0], co[15:8], co[23:16], ce[7:0], ce[15:8],
                          ce[23:16], len[7:0], c[11:0], 12'(h - 1 - line)});
      endfunction

      function void rle_byte(logic [7:0] b, bit four);
         int unsigned n, data, tot, idx;
         case (state)
            RLE_RUN: begin
               n = run_left;
               run_left = 0;
               state = RLE_IDLE;
               if (four) place(n, colors[b[7:4]], colors[b[3:0]], 0);
               else place(n, colors[b], colors[b], 0);
            end
            RLE_ESC: begin
               state = RLE_IDLE;
               if (b == bpsd_pkg::ESC_EOL) begin
                  col = 0;
                  line = sat16(line + 1);
               end else if (b == bpsd_pkg::ESC_EOB) begin
                  finished = 1;
                  spans.push_back({1'b1, 80'd0});
               end else if (b == bpsd_pkg::ESC_DELTA) begin
                  state = RLE_DX;
               end else begin
                  abs_total = b;
                  data = four ? (b + 1) >> 1 : b;
                  run_left = data + (data & 1);
                  state = RLE_ABS;
               end
            end
            RLE_DX: begin
               col = sat16(col + b);
               state = RLE_DY;
            end
            RLE_DY: begin
               line = sat16(line + b);
               state = RLE_IDLE;
            end
            RLE_ABS: begin
               data = four ? (abs_total + 1) >> 1 : abs_total;
               tot = data + (data & 1);
               idx = run_left <= tot ? tot - run_left : tot;
               if (run_left > 0) run_left--;
               if (run_left == 0) state = RLE_IDLE;
               if (idx < data) begin
                  if (four) begin
                     n = abs_total - 2 * idx;
                     if (n > 2) n = 2;
                     place(n, colors[b[7:4]], colors[b[3:0]], 0);
                  end else place(1, colors[b], colors[b], 0);
               end
            end
            default: begin
               if (b != 0) begin
                  run_left = b;
                  state = RLE_RUN;
               end else state = RLE_ESC;
            end
         endcase
      endfunction

      function void raw_byte(logic [7:0] b, int unsigned dep);
         int unsigned data_bytes, padded;
         if (dep == bpsd_pkg::DEPTH_4BIT) data_bytes = (w + 1) >> 1;
         else if (dep == bpsd_pkg::DEPTH_8BIT) data_bytes = w;
         else data_bytes = 3 * w;
         padded = (data_bytes + 3) & ~32'd3;
         if (row_bytes < data_bytes) begin
            if (dep == bpsd_pkg::DEPTH_4BIT) place(2, colors[b[7:4]], colors[b[3:0]], 1);
            else if (dep == bpsd_pkg::DEPTH_8BIT) place(1, colors[b], colors[b], 1);
            else if (bgr_step == 0) begin
               bgr[7:0] = b;
               bgr_step = 1;
            end else if (bgr_step == 1) begin
               bgr[15:8] = b;
               bgr_step = 2;
            end else begin
               bgr[23:16] = b;
               bgr_step = 0;
               place(1, bgr, bgr, 1);
            end
         end
         row_bytes++;
         if (row_bytes >= padded) begin
            row_bytes = 0;
            col = 0;
            line = sat16(line + 1);
            bgr_step = 0;
         end
      endfunction

      function void note(logic [1:0] op, logic [39:0] d);
         int unsigned dep;
         if (op == bpsd_pkg::OP_PALETTE) begin
            colors[d[15:8]] = {d[23:16], d[31:24], d[39:32]};
            return;
         end
         if (op == bpsd_pkg::OP_START) begin
            restart();
            return;
         end
         if (op != bpsd_pkg::OP_PIXEL || finished) return;
         w = clamp_dim(width);
         h = clamp_dim(height);
         dep = depth > bpsd_pkg::DEPTH_24BIT ? bpsd_pkg::DEPTH_24BIT : depth;
         if (rle && dep != bpsd_pkg::DEPTH_24BIT)
            rle_byte(d[7:0], dep == bpsd_pkg::DEPTH_4BIT);
         else raw_byte(d[7:0], dep);
      endfunction

      function void check(logic [80:0] got);
         int lo [10] = '{0, 12, 24, 32, 40, 48, 56, 64, 72, 80};
         int wd [10] = '{12, 12, 8, 8, 8, 8, 8, 8, 8, 1};
         string nm [10] = '{"display_row", "start_column", "span_length", "even_red",
                            "even_green", "even_blue", "odd_red", "odd_green",
                            "odd_blue", "image_done"};
         logic [80:0] want, e, a;
         if (spans.size() == 0) begin
            $display("%0t: unexpected span %h", $time, got);
            errors++;
            return;
         end
         want = spans.pop_front();
         for (int i = 0; i < 10; i++) begin
            e = (want >> lo[i]) & ((81'd1 << wd[i]) - 1);
            a = (got >> lo[i]) & ((81'd1 << wd[i]) - 1);
            if (e != a) begin
               $display("%0t: %s expected %0d actual %0d", $time, nm[i], e, a);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [1:0]  req_tuser;
   logic [39:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [79:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;

   span_scoreboard decoded;
   bit          quiet, hold_request, hold_done;
   int          items_sent, stall_left, long_hold, cycles;

   bmp_pixel_stream_decoder u_dut (.*);

   initial clock = 0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done <= 1;
         long_hold <= 300;
         rsp_tready <= 0;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_tready <= long_hold == 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= stall_left == 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 11);
         rsp_tready <= 0;
      end else rsp_tready <= 1;
   end

   always @(negedge clock)
      if (!reset && rsp_tvalid && rsp_tready) decoded.check({rsp_tlast, rsp_tdata});

   task automatic put(logic [1:0] op, logic [39:0] d);
      bit ok;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= d;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      decoded.note(op, d);
      items_sent++;
   endtask

   task automatic pixel(logic [7:0] b);
      put(bpsd_pkg::OP_PIXEL, {$urandom(), b});
   endtask

   task automatic csr_write(logic [1:0] idx, logic [12:0] v);
      bit ok;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      decoded.set_reg(idx, v);
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (decoded.spans.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic configure(int dep, int rle, int wv, int hv);
      settle();
      csr_write(bpsd_pkg::REG_DEPTH, 13'(dep));
      csr_write(bpsd_pkg::REG_RLE, 13'(rle));
      csr_write(bpsd_pkg::REG_WIDTH, 13'(wv));
      csr_write(bpsd_pkg::REG_HEIGHT, 13'(hv));
      csr_valid <= 0;
      put(bpsd_pkg::OP_START, 40'($urandom()));
   endtask

   function automatic logic [7:0] pick_count(int lo);
      return 8'($urandom_range(0, 3) == 0 ? $urandom_range(lo, 255)
                                          : $urandom_range(lo, lo + 8));
   endfunction

   task automatic rle_sequence(bit four);
      int k, n, data;
      k = $urandom_range(0, 39);
      if (k < 2) pixel(8'($urandom()));
      else if (k < 3) begin
         pixel(bpsd_pkg::ESC_DELTA);
         pixel(8'd0);
      end else if (k < 4) begin
         pixel(8'd0);
         pixel(bpsd_pkg::ESC_EOB);
      end else if (k < 10) begin
         pixel(8'd0);
         pixel(bpsd_pkg::ESC_EOL);
      end else if (k < 14) begin
         pixel(8'd0);
         pixel(bpsd_pkg::ESC_DELTA);
         pixel(8'($urandom_range(0, 9) == 0 ? 255 : $urandom_range(0, 3)));
         pixel(8'($urandom_range(0, 9) == 0 ? 255 : $urandom_range(0, 2)));
      end else if (k < 22) begin
         n = pick_count(3);
         data = four ? (n + 1) / 2 : n;
         pixel(8'd0);
         pixel(8'(n));
         repeat (data + (data & 1)) pixel(8'($urandom()));
      end else begin
         pixel(pick_count(1));
         pixel(8'($urandom()));
      end
   endtask

   task automatic run_phase(int dep, int rle, int wv, int hv, int count);
      int target;
      configure(dep, rle, wv, hv);
      target = items_sent + count;
      while (items_sent < target) begin
         if (decoded.finished) put(bpsd_pkg::OP_START, 40'($urandom()));
         else if ($urandom_range(0, 49) == 0) put(OP_UNUSED, 40'($urandom()));
         else if ($urandom_range(0, 49) == 0)
            put(bpsd_pkg::OP_PALETTE, {$urandom(), 8'($urandom())});
         else if (rle != 0 && dep != bpsd_pkg::DEPTH_24BIT)
            rle_sequence(dep == bpsd_pkg::DEPTH_4BIT);
         else pixel(8'($urandom()));
      end
   endtask

   initial begin
      decoded = new();
      decoded.depth = bpsd_pkg::DEPTH_8BIT;
      decoded.rle = 0;
      decoded.width = 1;
      decoded.height = 1;
      decoded.restart();
      reset <= 1;
      req_tvalid <= 0;
      req_tuser <= bpsd_pkg::OP_PIXEL;
      req_tdata <= 0;
      csr_valid <= 0;
      csr_index <= bpsd_pkg::REG_DEPTH;
      csr_data <= 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // whole palette first so no entry is read before it is written
      for (int i = 0; i < 256; i++)
         put(bpsd_pkg::OP_PALETTE, {24'($urandom()), 8'(i), 8'($urandom())});

      // rle8 escapes, clipping and absolute mode
      configure(bpsd_pkg::DEPTH_8BIT, 1, 16, 8);
      pixel(8'd255); pixel(8'd7);
      pixel(8'd0); pixel(bpsd_pkg::ESC_EOL);
      pixel(8'd0); pixel(bpsd_pkg::ESC_DELTA); pixel(8'd3); pixel(8'd1);
      pixel(8'd3); pixel(8'd255);
      pixel(8'd0); pixel(8'd3); pixel(8'd0); pixel(8'd128); pixel(8'd255); pixel(8'd9);
      put(OP_UNUSED, 40'hFF_FFFF_FFFF);
      pixel(8'd0); pixel(bpsd_pkg::ESC_EOB);
      pixel(8'd4); pixel(8'd4);
      // rle4 odd absolute run and run of nibble pairs
      configure(bpsd_pkg::DEPTH_4BIT, 1, 13, 6);
      pixel(8'd5); pixel(8'h1F);
      pixel(8'd0); pixel(8'd5); pixel(8'hF0); pixel(8'h0F); pixel(8'hAA); pixel(8'h55);
      pixel(8'd0); pixel(bpsd_pkg::ESC_EOB);

      run_phase(bpsd_pkg::DEPTH_8BIT, 0, 1, 1, 40);
      run_phase(bpsd_pkg::DEPTH_4BIT, 0, 5, 3, 120);
      run_phase(bpsd_pkg::DEPTH_24BIT, 0, 3, 4, 120);
      hold_request = 1;
      run_phase(bpsd_pkg::DEPTH_8BIT, 1, 16, 8, 150);
      run_phase(bpsd_pkg::DEPTH_4BIT, 1, 13, 6, 150);
      run_phase(bpsd_pkg::DEPTH_24BIT, 1, 4, 2, 80);
      run_phase(bpsd_pkg::DEPTH_8BIT, 1, 4096, 4096, 120);
      run_phase(bpsd_pkg::DEPTH_4BIT, 0, 4096, 1, 60);
      run_phase(bpsd_pkg::DEPTH_8BIT, 0, 7, 4096, 80);
      for (int i = 0; i < 3; i++)
         run_phase($urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(1, 24),
                   $urandom_range(1, 12), 60);
      quiet = 1;
      run_phase(bpsd_pkg::DEPTH_8BIT, 1, 20, 10, 100);
      run_phase(bpsd_pkg::DEPTH_4BIT, 0, 9, 5, 80);

      settle();
      repeat (10) @(posedge clock);
      if (decoded.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
